FILE: src/bounded_substring_search_macros.svh
// Assertion macros for the substring search RTL
`ifndef BOUNDED_SUBSTRING_SEARCH_MACROS_SVH
`define BOUNDED_SUBSTRING_SEARCH_MACROS_SVH
`ifndef SYNTH
`define BSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSS_ASSERT(label, clk, rst_n, prop, msg)
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/bss_pkg.sv
// Shared types and constants of the bounded substring search
package bss_pkg;

    localparam int PATTERN_MAX_DEF    = 8;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int LEN_W   = 4;
    localparam int LIMIT_W = 16;
    localparam int CNT_W   = 17;
    localparam int PAT_W   = 64;

    localparam logic [1:0] MODE_FIRST_END   = 2'd0;
    localparam logic [1:0] MODE_FIRST_START = 2'd1;
    localparam logic [1:0] MODE_LAST_END    = 2'd2;

    localparam logic [1:0] CFG_PATTERN = 2'd0;
    localparam logic [1:0] CFG_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_MODE    = 2'd3;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

FILE: src/bss_cell.sv
// One window cell: holds a byte, passes it on, compares against its pattern byte
module bss_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bss_pkg::t_cell_ctl i_ctl,
    input  bss_pkg::t_byte    i_byte,
    input  bss_pkg::t_byte    i_pat,
    output bss_pkg::t_byte    o_byte,
    output logic              o_eq
);
    import bss_pkg::*;

    t_byte r_byte;
    t_byte n_byte;
    t_byte shifted;

    assign shifted = i_ctl.shift ? i_byte : r_byte;
    assign o_eq    = (shifted == i_pat);
    assign o_byte  = r_byte;

    always_comb begin
        n_byte = shifted;
        if (i_ctl.clear) begin
            n_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

endmodule

FILE: src/bss_out_buf.sv
// Output register with a skid stage for the result channel
module bss_out_buf #(
    parameter int W = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [W-1:0] i_data,
    input  logic         i_stall,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic         r_skid_valid;
    logic [W-1:0] r_data;
    logic [W-1:0] r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_load) begin
            if (r_valid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_data <= r_skid;
            end
        end else if (i_load) begin
            if (r_valid && i_stall) begin
                r_skid <= i_data;
            end else begin
                r_data <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/bounded_substring_search.sv
// Top level of the bounded substring search
//
// Bytes of a buffer arrive on the input channel (i_in_valid / o_in_stall),
// one transfer per byte with i_last_byte marking the final one; a zero byte
// also closes the buffer and is not counted. Results leave on the output
// channel (o_out_valid / i_out_stall) as o_position and o_found.
// Configuration registers are written through i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data; ready is always high.
// Throughput: one byte per cycle while o_in_stall is low. The window is a row
// of PATTERN_MAX cells that shift on every accepted nonzero byte and compare
// in parallel, so a result is registered in the cycle its byte is accepted
// and leaves through the output register. Each buffer gives exactly one
// result: at the first accepted match (first-match modes) or at the close.
// When the receiver stalls, the output register holds and a skid stage takes
// one more result; o_in_stall rises only while that skid stage is full.
// Reset (synchronous, active low) clears the window, the byte count, the
// configuration registers and the valid flags of both output stages.
module bounded_substring_search #(
    parameter int PATTERN_MAX    = bss_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_WIDTH = bss_pkg::POSITION_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [bss_pkg::PAT_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [POSITION_WIDTH:0]   o_position,
    output logic                             o_found
);
    import bss_pkg::*;

    `include "bounded_substring_search_macros.svh"

    localparam int PW = POSITION_WIDTH;
    localparam int RW = PW + 2;
    localparam logic [32:0] POS_MAX = (33'(1) << PW) - 33'(1);

    function automatic logic [PW-1:0] sat_pos(input logic [CNT_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > POS_MAX) begin
            return {PW{1'b1}};
        end
        return w[PW-1:0];
    endfunction

    function automatic logic [PW:0] minus_one(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] d;
        d = v - CNT_W'(1);
        if (v == '0) begin
            return {(PW+1){1'b1}};
        end
        return {1'b0, sat_pos(d)};
    endfunction

    logic [PAT_W-1:0]   r_pattern;
    logic [LEN_W-1:0]   r_len;
    logic [LIMIT_W-1:0] r_limit;
    logic [1:0]         r_mode;
    logic [CNT_W-1:0]   r_count;
    logic [PW-1:0]      r_last_end;
    logic               r_match_seen;
    logic               r_reported;

    logic [CNT_W-1:0]   n_count;
    logic [PW-1:0]      n_last_end;
    logic               n_match_seen;
    logic               n_reported;

    logic [LEN_W-1:0]   len_cap;
    logic [LEN_W-1:0]   eff_len;
    logic               zero_seen;

    logic               in_fire;
    logic               byte_nz;
    logic               shift;
    logic               close;
    t_cell_ctl          cell_ctl;

    t_byte              win [PATTERN_MAX];
    t_byte              pat_sel [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] mask;

    logic               hit;
    logic               ok;
    logic               mode_last;
    logic               mode_start;
    logic               match_rep;
    logic               close_rep;
    logic               seen_now;
    logic [PW-1:0]      last_end_now;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   cnt_now;
    logic [CNT_W-1:0]   cnt_lim;
    logic [CNT_W-1:0]   start_pos;
    logic [PW:0]        res_pos;
    logic               res_found;
    logic               load;
    logic [RW-1:0]      out_data;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
            r_limit   <= '0;
            r_mode    <= MODE_FIRST_END;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATTERN: r_pattern <= i_cfg_data;
                CFG_LENGTH:  r_len     <= i_cfg_data[LEN_W-1:0];
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_W-1:0];
                CFG_MODE:    r_mode    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // effective pattern length: clamp, then stop at the first zero byte
    always_comb begin
        len_cap   = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_len;
        eff_len   = len_cap;
        zero_seen = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (!zero_seen && (LEN_W'(k) < len_cap) && (r_pattern[8*k +: 8] == 8'd0)) begin
                eff_len   = LEN_W'(k);
                zero_seen = 1'b1;
            end
        end
    end

    assign in_fire = i_in_valid && !o_in_stall;
    assign byte_nz = |i_data_byte;
    assign shift   = in_fire && byte_nz;
    assign close   = in_fire && (!byte_nz || i_last_byte);

    assign cell_ctl.shift = shift;
    assign cell_ctl.clear = close;

    // window cells
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [2:0] idx;
        assign idx        = 3'(eff_len - LEN_W'(j) - LEN_W'(1));
        assign pat_sel[j] = r_pattern[8*idx +: 8];
        assign mask[j]    = LEN_W'(j) < eff_len;

        if (j == 0) begin : g_head
            bss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_byte  (i_data_byte),
                .i_pat   (pat_sel[j]),
                .o_byte  (win[j]),
                .o_eq    (eq[j])
            );
        end else begin : g_body
            bss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_byte  (win[j-1]),
                .i_pat   (pat_sel[j]),
                .o_byte  (win[j]),
                .o_eq    (eq[j])
            );
        end
    end

    // match and result selection
    assign cnt_inc    = (&r_count) ? r_count : r_count + CNT_W'(1);
    assign cnt_now    = shift ? cnt_inc : r_count;
    assign start_pos  = cnt_inc - CNT_W'(eff_len);
    assign hit        = shift && (eff_len != '0) && (&(eq | ~mask));
    assign ok         = hit && (start_pos < CNT_W'(r_limit));
    assign mode_last  = (r_mode == MODE_LAST_END);
    assign mode_start = (r_mode == MODE_FIRST_START);
    assign match_rep  = ok && !mode_last && !r_reported;
    assign close_rep  = close && !r_reported && !match_rep;
    assign seen_now   = r_match_seen || (ok && mode_last);
    assign last_end_now = (ok && mode_last) ? sat_pos(cnt_inc) : r_last_end;
    assign cnt_lim    = (cnt_now < CNT_W'(r_limit)) ? cnt_now : CNT_W'(r_limit);
    assign load       = match_rep || close_rep;

    always_comb begin
        res_found = 1'b0;
        if (match_rep) begin
            res_found = 1'b1;
            res_pos   = mode_start ? minus_one(start_pos) : {1'b0, sat_pos(cnt_inc)};
        end else if (eff_len == '0) begin
            res_pos   = mode_start ? {(PW+1){1'b1}} : '0;
        end else if (mode_last && seen_now) begin
            res_found = 1'b1;
            res_pos   = {1'b0, last_end_now};
        end else begin
            res_pos   = mode_start ? minus_one(cnt_lim) : {1'b0, sat_pos(cnt_lim)};
        end
    end

    always_comb begin
        n_count      = r_count;
        n_last_end   = r_last_end;
        n_match_seen = r_match_seen;
        n_reported   = r_reported;
        if (close) begin
            n_count      = '0;
            n_last_end   = '0;
            n_match_seen = 1'b0;
            n_reported   = 1'b0;
        end else if (shift) begin
            n_count      = cnt_inc;
            n_last_end   = last_end_now;
            n_match_seen = seen_now;
            n_reported   = r_reported || match_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_end   <= '0;
            r_match_seen <= 1'b0;
            r_reported   <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_last_end   <= n_last_end;
            r_match_seen <= n_match_seen;
            r_reported   <= n_reported;
        end
    end

    // result output
    bss_out_buf #(
        .W (RW)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_data  ({res_pos, res_found}),
        .i_stall (i_out_stall),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (out_data)
    );

    assign o_position = $signed(out_data[RW-1:1]);
    assign o_found    = out_data[0];

    `BSS_ASSERT(a_stall_needs_result, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "input stalled with no result held")
    `BSS_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, close, (r_count == '0 && !r_reported && !r_match_seen), "buffer state not cleared after close")
    `BSS_ASSERT(a_seen_needs_bytes, i_clk, i_rst_n, r_match_seen |-> (r_count != '0), "match recorded with empty byte count")

endmodule
